/* rtl/cst_pkg.sv */
package cst_pkg;

    localparam int POSITION_BITS = 32;
    localparam int LENGTH_BITS   = 16;

    localparam int MAX_TOKENS    = 3;
    localparam int QUEUE_SLOTS   = 4;

    localparam logic [15:0] OUT_LEN_MAX = 16'hFFFF;
    localparam logic [15:0] COL_MAX     = 16'hFFFF;
    localparam logic [19:0] LINE_MAX    = 20'hFFFFF;

    typedef enum logic [4:0] {
        KIND_EOF      = 5'd0,
        KIND_PLUS     = 5'd1,
        KIND_MINUS    = 5'd2,
        KIND_ARROW    = 5'd3,
        KIND_STAR     = 5'd4,
        KIND_SLASH    = 5'd5,
        KIND_AMP      = 5'd6,
        KIND_LPAREN   = 5'd7,
        KIND_RPAREN   = 5'd8,
        KIND_LBRACK   = 5'd9,
        KIND_RBRACK   = 5'd10,
        KIND_LBRACE   = 5'd11,
        KIND_RBRACE   = 5'd12,
        KIND_SEMI     = 5'd13,
        KIND_COMMA    = 5'd14,
        KIND_PERIOD   = 5'd15,
        KIND_ELLIPSIS = 5'd16,
        KIND_ASSIGN   = 5'd17,
        KIND_EQ       = 5'd18,
        KIND_NE       = 5'd19,
        KIND_GT       = 5'd20,
        KIND_GE       = 5'd21,
        KIND_LT       = 5'd22,
        KIND_LE       = 5'd23,
        KIND_NUMBER   = 5'd24,
        KIND_IDENT    = 5'd25,
        KIND_ERROR    = 5'd26
    } t_kind;

    typedef enum logic [3:0] {
        M_IDLE,
        M_NUM,
        M_IDENT,
        M_SLASH,
        M_MINUS,
        M_DOT1,
        M_DOT2,
        M_EQ,
        M_BANG,
        M_GT,
        M_LT,
        M_LINEC,
        M_BLOCK,
        M_BLOCK_STAR
    } t_mode;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] number_value;
        logic [31:0] start_offset;
        logic [15:0] token_length;
        logic [19:0] line_number;
        logic [15:0] column_number;
        logic        last_of_run;
    } t_token;

    // tokens produced by one accepted word, in emission order
    typedef struct packed {
        logic [1:0]   count;
        t_token [2:0] tok;
    } t_batch;

endpackage

/* rtl/cst_ifs.sv */
interface cst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, char_code, end_of_text, input ready);
    modport sink   (input valid, char_code, end_of_text, output ready);
endinterface

interface cst_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [31:0] number_value;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic [19:0] line_number;
    logic [15:0] column_number;
    logic        last_of_run;

    modport source (output valid, token_kind, number_value, start_offset, token_length,
                    line_number, column_number, last_of_run, input ready);
    modport sink   (input valid, token_kind, number_value, start_offset, token_length,
                    line_number, column_number, last_of_run, output ready);
endinterface

/* rtl/cst_lexer.sv */
module cst_lexer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_char,
    input  logic                 i_eot,
    output cst_pkg::t_batch      o_batch
);

    localparam int P = cst_pkg::POSITION_BITS;
    localparam int L = cst_pkg::LENGTH_BITS;

    cst_pkg::t_mode r_mode, n_mode;
    logic [31:0]    r_acc, n_acc;
    logic [P-1:0]   r_start, n_start;
    logic [L-1:0]   r_len, n_len;
    logic [P-1:0]   r_pos, n_pos;
    logic [19:0]    r_line, n_line;
    logic [P-1:0]   r_head, n_head;
    logic [19:0]    r_pline, n_pline;
    logic [15:0]    r_pcol, n_pcol;

    logic [P-1:0]   col_diff;
    logic [15:0]    here_col;
    logic [15:0]    pend_len;

    logic [1:0]           fl_n;
    cst_pkg::t_token      fl0, fl1;
    logic [1:0]           grp_n;
    cst_pkg::t_token      grp0, grp1;
    logic                 tail_v;
    cst_pkg::t_token      tail;
    logic                 do_idle;
    logic [1:0]           total;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
    endfunction

    function automatic cst_pkg::t_kind single_kind(input logic [7:0] c);
        cst_pkg::t_kind k;
        case (c)
            "+":     k = cst_pkg::KIND_PLUS;
            "*":     k = cst_pkg::KIND_STAR;
            "&":     k = cst_pkg::KIND_AMP;
            "(":     k = cst_pkg::KIND_LPAREN;
            ")":     k = cst_pkg::KIND_RPAREN;
            "[":     k = cst_pkg::KIND_LBRACK;
            "]":     k = cst_pkg::KIND_RBRACK;
            "{":     k = cst_pkg::KIND_LBRACE;
            "}":     k = cst_pkg::KIND_RBRACE;
            ";":     k = cst_pkg::KIND_SEMI;
            ",":     k = cst_pkg::KIND_COMMA;
            default: k = cst_pkg::KIND_ERROR;
        endcase
        return k;
    endfunction

    function automatic cst_pkg::t_token make_tok(
        input cst_pkg::t_kind kind,
        input logic [31:0]    value,
        input logic [P-1:0]   start,
        input logic [15:0]    len,
        input logic [19:0]    line,
        input logic [15:0]    col
    );
        cst_pkg::t_token t;
        t.kind          = kind;
        t.number_value  = value;
        t.start_offset  = 32'(start);
        t.token_length  = len;
        t.line_number   = line;
        t.column_number = col;
        t.last_of_run   = 1'b0;
        return t;
    endfunction

    assign col_diff = r_pos - r_head;
    assign here_col = (col_diff > P'(cst_pkg::COL_MAX)) ? cst_pkg::COL_MAX : 16'(col_diff);
    assign pend_len = (r_len > L'(cst_pkg::OUT_LEN_MAX)) ? cst_pkg::OUT_LEN_MAX : 16'(r_len);

    // what a pending token turns into when it is cut short
    always_comb begin
        fl_n = 2'd1;
        fl0  = make_tok(cst_pkg::KIND_ERROR, 32'd0, r_start, 16'd1, r_pline, r_pcol);
        fl1  = make_tok(cst_pkg::KIND_PERIOD, 32'd0, r_start + P'(1), 16'd1, r_pline,
                        (r_pcol != cst_pkg::COL_MAX) ? r_pcol + 16'd1 : r_pcol);
        case (r_mode)
            cst_pkg::M_NUM:   fl0 = make_tok(cst_pkg::KIND_NUMBER, r_acc, r_start, pend_len,
                                             r_pline, r_pcol);
            cst_pkg::M_IDENT: fl0.kind = cst_pkg::KIND_IDENT;
            cst_pkg::M_SLASH: fl0.kind = cst_pkg::KIND_SLASH;
            cst_pkg::M_MINUS: fl0.kind = cst_pkg::KIND_MINUS;
            cst_pkg::M_DOT1:  fl0.kind = cst_pkg::KIND_PERIOD;
            cst_pkg::M_DOT2: begin
                fl0.kind = cst_pkg::KIND_PERIOD;
                fl_n     = 2'd2;
            end
            cst_pkg::M_EQ:    fl0.kind = cst_pkg::KIND_ASSIGN;
            cst_pkg::M_BANG:  fl0.kind = cst_pkg::KIND_ERROR;
            cst_pkg::M_GT:    fl0.kind = cst_pkg::KIND_GT;
            cst_pkg::M_LT:    fl0.kind = cst_pkg::KIND_LT;
            cst_pkg::M_BLOCK,
            cst_pkg::M_BLOCK_STAR: fl0.kind = cst_pkg::KIND_ERROR;
            default:          fl_n = 2'd0;
        endcase
        if (r_mode == cst_pkg::M_IDENT || r_mode == cst_pkg::M_BLOCK ||
            r_mode == cst_pkg::M_BLOCK_STAR) begin
            fl0.token_length = pend_len;
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_acc   = r_acc;
        n_start = r_start;
        n_len   = r_len;
        n_pos   = r_pos;
        n_line  = r_line;
        n_head  = r_head;
        n_pline = r_pline;
        n_pcol  = r_pcol;
        grp_n   = 2'd0;
        grp0    = fl0;
        grp1    = fl1;
        tail_v  = 1'b0;
        tail    = make_tok(single_kind(i_char), 32'd0, r_pos, 16'd1, r_line, here_col);
        do_idle = 1'b0;

        if (i_eot) begin
            grp_n   = fl_n;
            tail_v  = 1'b1;
            tail    = make_tok(cst_pkg::KIND_EOF, 32'd0, r_pos, 16'd0, r_line, here_col);
            n_mode  = cst_pkg::M_IDLE;
            n_acc   = '0;
            n_start = '0;
            n_len   = '0;
            n_pos   = '0;
            n_line  = 20'd1;
            n_head  = '0;
            n_pline = '0;
            n_pcol  = '0;
        end else begin
            n_pos = r_pos + P'(1);
            case (r_mode)
                cst_pkg::M_NUM: begin
                    if (is_digit(i_char)) begin
                        n_acc = (r_acc << 3) + (r_acc << 1) + 32'(i_char - "0");
                        n_len = (r_len != '1) ? r_len + L'(1) : r_len;
                    end else begin
                        do_idle = 1'b1;
                    end
                end
                cst_pkg::M_IDENT: begin
                    if (is_letter(i_char) || is_digit(i_char)) begin
                        n_len = (r_len != '1) ? r_len + L'(1) : r_len;
                    end else begin
                        do_idle = 1'b1;
                    end
                end
                cst_pkg::M_SLASH: begin
                    if (i_char == "/") begin
                        n_mode = cst_pkg::M_LINEC;
                    end else if (i_char == "*") begin
                        n_mode = cst_pkg::M_BLOCK;
                        n_len  = L'(2);
                    end else begin
                        do_idle = 1'b1;
                    end
                end
                cst_pkg::M_MINUS: begin
                    if (i_char == ">") begin
                        grp_n = 2'd1;
                        grp0  = make_tok(cst_pkg::KIND_ARROW, 32'd0, r_start, 16'd2,
                                         r_pline, r_pcol);
                        n_mode = cst_pkg::M_IDLE;
                    end else begin
                        do_idle = 1'b1;
                    end
                end
                cst_pkg::M_DOT1: begin
                    if (i_char == ".") begin
                        n_mode = cst_pkg::M_DOT2;
                    end else begin
                        do_idle = 1'b1;
                    end
                end
                cst_pkg::M_DOT2: begin
                    if (i_char == ".") begin
                        grp_n = 2'd1;
                        grp0  = make_tok(cst_pkg::KIND_ELLIPSIS, 32'd0, r_start, 16'd3,
                                         r_pline, r_pcol);
                        n_mode = cst_pkg::M_IDLE;
                    end else begin
                        do_idle = 1'b1;
                    end
                end
                cst_pkg::M_EQ, cst_pkg::M_BANG, cst_pkg::M_GT, cst_pkg::M_LT: begin
                    if (i_char == "=") begin
                        grp_n = 2'd1;
                        grp0  = make_tok(cst_pkg::KIND_EQ, 32'd0, r_start, 16'd2,
                                         r_pline, r_pcol);
                        case (r_mode)
                            cst_pkg::M_BANG: grp0.kind = cst_pkg::KIND_NE;
                            cst_pkg::M_GT:   grp0.kind = cst_pkg::KIND_GE;
                            cst_pkg::M_LT:   grp0.kind = cst_pkg::KIND_LE;
                            default:         grp0.kind = cst_pkg::KIND_EQ;
                        endcase
                        n_mode = cst_pkg::M_IDLE;
                    end else begin
                        do_idle = 1'b1;
                    end
                end
                cst_pkg::M_LINEC: begin
                    // newline ends the comment and is then counted as usual
                    if (i_char == 8'h0A) begin
                        do_idle = 1'b1;
                    end
                end
                cst_pkg::M_BLOCK, cst_pkg::M_BLOCK_STAR: begin
                    n_len = (r_len != '1) ? r_len + L'(1) : r_len;
                    if (r_mode == cst_pkg::M_BLOCK_STAR && i_char == "/") begin
                        n_mode = cst_pkg::M_IDLE;
                    end else begin
                        if (i_char == 8'h0A) begin
                            n_line = (r_line != cst_pkg::LINE_MAX) ? r_line + 20'd1 : r_line;
                            n_head = r_pos + P'(1);
                        end
                        n_mode = (i_char == "*") ? cst_pkg::M_BLOCK_STAR : cst_pkg::M_BLOCK;
                    end
                end
                default: do_idle = 1'b1;
            endcase

            if (do_idle) begin
                grp_n  = fl_n;
                n_mode = cst_pkg::M_IDLE;
                if (i_char == 8'h0A) begin
                    n_line = (r_line != cst_pkg::LINE_MAX) ? r_line + 20'd1 : r_line;
                    n_head = r_pos + P'(1);
                end else if (!is_space(i_char)) begin
                    n_start = r_pos;
                    n_pline = r_line;
                    n_pcol  = here_col;
                    n_len   = L'(1);
                    if (is_digit(i_char)) begin
                        n_mode = cst_pkg::M_NUM;
                        n_acc  = 32'(i_char - "0");
                    end else if (is_letter(i_char)) begin
                        n_mode = cst_pkg::M_IDENT;
                    end else begin
                        case (i_char)
                            "/":     n_mode = cst_pkg::M_SLASH;
                            "-":     n_mode = cst_pkg::M_MINUS;
                            ".":     n_mode = cst_pkg::M_DOT1;
                            "=":     n_mode = cst_pkg::M_EQ;
                            "!":     n_mode = cst_pkg::M_BANG;
                            ">":     n_mode = cst_pkg::M_GT;
                            "<":     n_mode = cst_pkg::M_LT;
                            default: begin
                                tail_v  = 1'b1;
                                n_start = r_start;
                                n_pline = r_pline;
                                n_pcol  = r_pcol;
                                n_len   = r_len;
                            end
                        endcase
                    end
                end
            end
        end
    end

    // pack the group and the trailing token into emission order
    always_comb begin
        total           = grp_n + {1'b0, tail_v};
        o_batch.count   = i_fire ? total : 2'd0;
        o_batch.tok[0]  = (grp_n != 2'd0) ? grp0 : tail;
        o_batch.tok[1]  = (grp_n == 2'd2) ? grp1 : tail;
        o_batch.tok[2]  = tail;
        o_batch.tok[0].last_of_run = (total == 2'd1);
        o_batch.tok[1].last_of_run = (total == 2'd2);
        o_batch.tok[2].last_of_run = (total == 2'd3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= cst_pkg::M_IDLE;
            r_acc   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_pos   <= '0;
            r_line  <= 20'd1;
            r_head  <= '0;
            r_pline <= '0;
            r_pcol  <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_start <= n_start;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_line  <= n_line;
            r_head  <= n_head;
            r_pline <= n_pline;
            r_pcol  <= n_pcol;
        end
    end

endmodule

/* rtl/cst_outq.sv */
module cst_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cst_pkg::t_batch  i_batch,
    input  logic             i_pop,
    output logic             o_ready,
    output logic             o_valid,
    output cst_pkg::t_token  o_head
);

    localparam int SLOTS = cst_pkg::QUEUE_SLOTS;
    localparam int CW    = $clog2(SLOTS + 1);

    cst_pkg::t_token r_slot [SLOTS];
    cst_pkg::t_token n_slot [SLOTS];
    cst_pkg::t_token shifted [SLOTS];
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   keep;

    // a full batch must fit behind whatever is still waiting
    assign o_ready = (r_cnt <= CW'(SLOTS - cst_pkg::MAX_TOKENS));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_slot[0];
    assign keep    = r_cnt - CW'(i_pop);

    always_comb begin
        for (int i = 0; i < SLOTS - 1; i++) begin
            shifted[i] = i_pop ? r_slot[i + 1] : r_slot[i];
        end
        shifted[SLOTS-1] = r_slot[SLOTS-1];
        for (int i = 0; i < SLOTS; i++) begin
            n_slot[i] = shifted[i];
            if (CW'(i) >= keep && (CW'(i) - keep) < CW'(i_batch.count)) begin
                n_slot[i] = i_batch.tok[2'(CW'(i) - keep)];
            end
        end
        n_cnt = keep + CW'(i_batch.count);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOTS; i++) begin
            r_slot[i] <= n_slot[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

/* rtl/c_subset_tokenizer_top.sv */
// Streaming tokenizer for a small C subset.
// i_in carries one source byte per word (char_code), or an end-of-text mark
// (end_of_text), which flushes any pending token and closes with an eof token.
// o_out carries one token per word: kind, value, start offset, length, line,
// column, and last_of_run on the final token that one input word caused.
// A byte yields zero to three tokens; a pending token (number, identifier,
// two-character operator) leaves when the byte after it arrives.
// Throughput: one input word per cycle while i_in.ready is high.
// A token is registered into the queue as its word is accepted, then waits its turn.
// Tokens wait in a four-entry register queue; i_in.ready is high while at
// most one token waits, so a stalled receiver holds off input once two
// tokens wait, and nothing is lost while o_out waits.
// Reset (i_rst_n low, synchronous) empties the queue and returns the scan to
// offset 0, line 1; eof does the same to the scan state.
module c_subset_tokenizer_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cst_in_if.sink       i_in,
    cst_out_if.source    o_out
);

    cst_pkg::t_batch  batch;
    cst_pkg::t_token  head;
    logic             fire;
    logic             pop;
    logic             q_ready;
    logic             q_valid;

    assign i_in.ready = q_ready;
    assign fire       = i_in.valid & q_ready;
    assign pop        = q_valid & o_out.ready;

    cst_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_char  (i_in.char_code),
        .i_eot   (i_in.end_of_text),
        .o_batch (batch)
    );

    cst_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_batch (batch),
        .i_pop   (pop),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_head  (head)
    );

    assign o_out.valid         = q_valid;
    assign o_out.token_kind    = head.kind;
    assign o_out.number_value  = head.number_value;
    assign o_out.start_offset  = head.start_offset;
    assign o_out.token_length  = head.token_length;
    assign o_out.line_number   = head.line_number;
    assign o_out.column_number = head.column_number;
    assign o_out.last_of_run   = head.last_of_run;

endmodule

/* rtl/cst_checker.sv */
module cst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [4:0]  i_kind,
    input logic [31:0] i_value,
    input logic [15:0] i_length,
    input logic [19:0] i_line,
    input logic        i_last
);

    // reset empties the token queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("token valid right after reset");

    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind == cst_pkg::KIND_EOF) |-> (i_length == 16'd0 && i_last))
        else $error("eof token not zero length or not last");

    a_value_only_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind != cst_pkg::KIND_NUMBER) |-> (i_value == 32'd0))
        else $error("non-number token carries a value");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_line != 20'd0))
        else $error("token on line zero");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_kind) && $stable(i_value)))
        else $error("stalled token changed");

endmodule

bind c_subset_tokenizer_top cst_checker u_cst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.token_kind),
    .i_value     (o_out.number_value),
    .i_length    (o_out.token_length),
    .i_line      (o_out.line_number),
    .i_last      (o_out.last_of_run)
);
